// ----- hdl/ihg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ihg_pkg;

  localparam int unsigned HDR_WORDS   = 10;
  localparam int unsigned HDR_BYTES   = 20;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  VER_IHL   = 8'h45;
  localparam logic [7:0]  TTL_VALUE = 8'd64;
  localparam logic [15:0] MASK16    = 16'hffff;

  // Word positions within the header
  localparam logic [3:0] W_VER    = 4'd0;
  localparam logic [3:0] W_TOTLEN = 4'd1;
  localparam logic [3:0] W_IDENT  = 4'd2;
  localparam logic [3:0] W_FRAG   = 4'd3;
  localparam logic [3:0] W_TTLPRO = 4'd4;
  localparam logic [3:0] W_CSUM   = 4'd5;
  localparam logic [3:0] W_SRC_HI = 4'd6;
  localparam logic [3:0] W_SRC_LO = 4'd7;
  localparam logic [3:0] W_DST_HI = 4'd8;
  localparam logic [3:0] W_DST_LO = 4'd9;
  localparam logic [3:0] W_LAST   = W_DST_LO;

  // Constant part of the header sum: version/IHL, TTL and header byte count
  localparam logic [15:0] SUM_CONST = {VER_IHL, 8'h00} + {TTL_VALUE, 8'h00}
                                      + 16'(HDR_BYTES);

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [11:0] total_len;
    logic [15:0] csum;
  } ihg_desc_t;

  function automatic logic [15:0] hdr_word_sel(input ihg_desc_t d, input logic [3:0] idx);
    logic [15:0] w;
    w = 16'h0000;
    unique case (idx)
      W_VER:    w = {VER_IHL, 8'h00};
      W_TOTLEN: w = {4'h0, d.total_len};
      W_IDENT:  w = 16'h0000;
      W_FRAG:   w = 16'h0000;
      W_TTLPRO: w = {TTL_VALUE, d.proto};
      W_CSUM:   w = d.csum;
      W_SRC_HI: w = d.src[31:16];
      W_SRC_LO: w = d.src[15:0];
      W_DST_HI: w = d.dst[31:16];
      W_DST_LO: w = d.dst[15:0];
      default:  w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ihg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ihg_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [31:0]       dest_addr,
  input  wire logic [7:0]        protocol,
  input  wire logic [10:0]       payload_length,
  input  wire logic [31:0]       source_addr,
  output logic                   q_push,
  output ihg_pkg::ihg_desc_t     q_data,
  input  wire logic              q_full
);
  import ihg_pkg::*;

  logic        s1_valid;
  logic [31:0] s1_src;
  logic [31:0] s1_dst;
  logic [7:0]  s1_proto;
  logic [11:0] s1_total_len;
  logic [17:0] s1_sum_a;
  logic [17:0] s1_sum_b;

  logic        s2_valid;
  ihg_desc_t   s2_desc;

  logic        s1_adv;
  logic        s2_adv;
  logic        accept;
  logic [18:0] sum_all;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign s2_adv = !s2_valid || !q_full;
  assign s1_adv = !s1_valid || s2_adv;
  assign full   = !s1_adv;
  assign accept = push && !full;

  assign q_push = s2_valid && !q_full;
  assign q_data = s2_desc;

  // Ones'-complement sum with end-around carry, two folds cover ten words
  assign sum_all = 19'(s1_sum_a) + 19'(s1_sum_b);
  assign fold1   = 17'(sum_all[15:0]) + 17'(sum_all[18:16]);
  assign fold2   = fold1[15:0] + 16'(fold1[16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= accept;
      if (s2_adv) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src       <= source_addr;
      s1_dst       <= dest_addr;
      s1_proto     <= protocol;
      s1_total_len <= 12'(payload_length) + 12'(HDR_BYTES);
      s1_sum_a     <= 18'(source_addr[31:16]) + 18'(source_addr[15:0])
                      + 18'(dest_addr[31:16]);
      s1_sum_b     <= 18'(dest_addr[15:0]) + 18'(payload_length) + 18'(protocol)
                      + 18'(SUM_CONST);
    end
    if (s2_adv && s1_valid) begin
      s2_desc.src       <= s1_src;
      s2_desc.dst       <= s1_dst;
      s2_desc.proto     <= s1_proto;
      s2_desc.total_len <= s1_total_len;
      s2_desc.csum      <= ~fold2 & MASK16;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ihg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ihg_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  ihg_pkg::ihg_desc_t     wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output ihg_pkg::ihg_desc_t     rd_data,
  output logic                   empty
);
  import ihg_pkg::*;

  ihg_desc_t             entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

// ----- hdl/ihg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ihg_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  ihg_pkg::ihg_desc_t     q_data,
  output logic                   empty,
  input  wire logic              pop,
  output logic [15:0]            header_word,
  output logic [3:0]             word_index,
  output logic                   last
);
  import ihg_pkg::*;

  ihg_desc_t   cur;
  logic        cur_valid;
  logic [3:0]  cnt;
  logic        out_valid;
  logic        load_out;
  logic        cur_done;

  assign empty    = !out_valid;
  assign load_out = cur_valid && (!out_valid || pop);
  assign cur_done = load_out && (cnt == W_LAST);
  // Refill on the beat that sends the last word so headers run back to back
  assign q_pop    = !q_empty && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        cnt       <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
        cnt       <= '0;
      end else if (load_out) begin
        cnt <= cnt + 1'b1;
      end
      if (load_out) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (load_out) begin
      header_word <= hdr_word_sel(cur, cnt);
      word_index  <= cnt;
      last        <= (cnt == W_LAST);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ipv4_header_generator.sv -----
// IPv4 header generator. Each request (destination address, protocol,
// payload length) produces a 20-byte header as ten 16-bit big-endian beats,
// word_index 0..9, last set on the tenth. The source address comes from the
// source_addr register; write it only while no request is in flight. Header
// checksum is computed in a two-stage front pipeline, the finished header
// waits in a two-entry queue; the back end sends one word per cycle while
// the result side pops, and requests are taken while earlier headers go out.
// A request passes both front stages, the queue and the back end's header
// register before its first word reaches the result ports; full rises when
// the front pipeline and the queue hold headers the back end has not started.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_header_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        source_addr_we,
  input  wire logic [31:0] source_addr,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] dest_addr,
  input  wire logic [7:0]  protocol,
  input  wire logic [10:0] payload_length,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      header_word,
  output logic [3:0]       word_index,
  output logic             last
);
  import ihg_pkg::*;

  logic [31:0] src_reg;
  logic        q_wr;
  ihg_desc_t   q_wr_data;
  logic        q_full;
  logic        q_rd;
  ihg_desc_t   q_rd_data;
  logic        q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_reg <= '0;
    end else if (source_addr_we) begin
      src_reg <= source_addr;
    end
  end

  ihg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .dest_addr      (dest_addr),
    .protocol       (protocol),
    .payload_length (payload_length),
    .source_addr    (src_reg),
    .q_push         (q_wr),
    .q_data         (q_wr_data),
    .q_full         (q_full)
  );

  ihg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  ihg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_rd),
    .q_data      (q_rd_data),
    .empty       (empty),
    .pop         (pop),
    .header_word (header_word),
    .word_index  (word_index),
    .last        (last)
  );

endmodule
`default_nettype wire

// ----- hdl/ihg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ihg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] header_word,
  input wire logic [3:0]  word_index,
  input wire logic        last
);

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (word_index == 4'd9)))
    else $error("last flag does not match word index");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (word_index <= 4'd9))
    else $error("word index out of range");

  a_first_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && word_index == 4'd0) |-> (header_word == 16'h4500))
    else $error("first header word is not version/IHL");

  a_next_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=>
      (!empty && word_index == $past(word_index) + 4'd1))
    else $error("header words not sent in order without gaps");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(header_word) && $stable(word_index)))
    else $error("stalled result beat changed");

endmodule

bind ipv4_header_generator ihg_checker u_ihg_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .header_word (header_word),
  .word_index  (word_index),
  .last        (last)
);
`default_nettype wire
